/* hw/rtl/qtp_pkg.sv */
// shared widths, constants and types of the quintic trajectory point block
`default_nettype none

package qtp_pkg;

  // field widths
  localparam int TIME_W = 32;
  localparam int POS_W  = 32;
  localparam int RATE_W = 48;
  localparam int DUR_W  = 31;

  // internal fixed-point widths
  localparam int FRAC_W   = 32;              // unsigned q0.32 time fraction
  localparam int ONE_W    = FRAC_W + 1;      // holds 1.0 in q0.32
  localparam int POLY_W   = FRAC_W + 4;      // 10 - 15 s + 6 s^2 in q4.32
  localparam int DIFF_W   = POS_W + 1;       // end minus start and its magnitude
  localparam int QUO_W    = 55;              // velocity and acceleration quotients
  localparam int DEN_SQ_W = 2 * DUR_W;       // duration squared

  // duration after reset
  localparam logic [DUR_W-1:0] DUR_RESET = DUR_W'(1000);

  // polynomial coefficients
  localparam int K_POS_10  = 10;
  localparam int K_POS_15  = 15;
  localparam int K_POS_6   = 6;
  localparam int K_VEL_30  = 30;
  localparam int K_ACC_60  = 60;

  // saturation limits of the rate outputs
  localparam logic [QUO_W-1:0]  MAG_NEG_LIM = QUO_W'(1) << (RATE_W - 1);
  localparam logic [QUO_W-1:0]  MAG_POS_LIM = (QUO_W'(1) << (RATE_W - 1)) - QUO_W'(1);
  localparam logic [RATE_W-1:0] RATE_MAX    = {1'b0, {(RATE_W-1){1'b1}}};
  localparam logic [RATE_W-1:0] RATE_MIN    = {1'b1, {(RATE_W-1){1'b0}}};

  // item data carried beside the fraction divider
  typedef struct packed {
    logic              hold;   // before start or past end: no motion
    logic              dneg;   // target below start
    logic [DIFF_W-1:0] dm;     // magnitude of target minus start
    logic [POS_W-1:0]  base;   // start, or target when past end
  } side_t;

  // item data carried beside the rate dividers
  typedef struct packed {
    logic             hold;
    logic             vneg;    // velocity sign
    logic             aneg;    // acceleration sign
    logic [POS_W-1:0] pos;     // finished position
  } tail_t;

  // one buffered result item
  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [RATE_W-1:0] vel;
    logic [RATE_W-1:0] acc;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/qtp_div.sv */
// pipelined restoring divider, one quotient bit per register stage
`default_nettype none

module qtp_div
  import qtp_pkg::*;
#(
  parameter int NUM_W = QUO_W,
  parameter int DEN_W = DUR_W
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [DEN_W-1:0] den,
  input  wire logic [DEN_W-1:0] rem_in,
  input  wire logic [NUM_W-1:0] num_in,
  output logic      [NUM_W-1:0] quo
);

  // remainder and shared dividend/quotient shift word per stage
  logic [DEN_W-1:0] rem [NUM_W];
  logic [NUM_W-1:0] nq  [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [DEN_W-1:0] rem_src;
    logic [NUM_W-1:0] nq_src;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_src = rem_in;
      assign nq_src  = num_in;
    end else begin : g_next
      assign rem_src = rem[i-1];
      assign nq_src  = nq[i-1];
    end

    // bring down the next dividend bit and try one subtract
    assign trial = {rem_src, nq_src[NUM_W-1]};
    assign diff  = trial - {1'b0, den};
    assign ge    = (trial >= {1'b0, den});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nq[i]  <= {nq_src[NUM_W-2:0], ge};
      end
    end
  end

  assign quo = nq[NUM_W-1];

endmodule

`default_nettype wire

/* hw/rtl/quintic_trajectory_point.sv */
// top level: minimum-jerk quintic reference position, velocity and acceleration
`default_nettype none

// One item a cycle goes in while in_stall is low, and one result item comes
// out per item, in order. An item passes from acceptance to the output through
// one input stage, a 32-stage divider that forms the q0.32 time fraction
// time_now / total_time (one quotient bit per stage), four multiplier stages
// for the polynomial terms, and 55-stage dividers for the velocity (by
// total_time) and acceleration (by total_time squared) scaling. Results land
// in a two-entry output buffer; the pipeline only halts while that buffer is
// full, so a waiting result does not block new items until two are held.
// total_time may be written only while no item is in flight; cfg_ready is
// always high. Times below zero give the start position, times at or past
// total_time give the target position, both with zero velocity and
// acceleration. Velocity and acceleration saturate at the 48-bit limits.

module quintic_trajectory_point
  import qtp_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,

  // configuration write
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [DUR_W-1:0]         total_time,

  // input items
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [TIME_W-1:0] time_now,
  input  wire logic signed [POS_W-1:0]  start_pos,
  input  wire logic signed [POS_W-1:0]  end_pos,

  // result items
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [POS_W-1:0]       ref_position,
  output logic signed [RATE_W-1:0]      ref_velocity,
  output logic signed [RATE_W-1:0]      ref_acceleration
);

  localparam int DEPTH = 1 + FRAC_W + 4 + QUO_W;
  localparam logic [ONE_W-1:0] ONE_Q = ONE_W'(1) << FRAC_W;

  function automatic logic [RATE_W-1:0] sat_rate(input logic neg,
                                                 input logic [QUO_W-1:0] mag);
    logic [RATE_W-1:0] res;
    if (neg) begin
      if (mag > MAG_NEG_LIM) res = RATE_MIN;
      else res = RATE_W'(0) - mag[RATE_W-1:0];
    end else begin
      if (mag > MAG_POS_LIM) res = RATE_MAX;
      else res = mag[RATE_W-1:0];
    end
    return res;
  endfunction

  logic                adv;
  logic [DEPTH-1:0]    vld;
  logic [DUR_W-1:0]    dur_ticks;
  logic [DEN_SQ_W-1:0] dur_sq;

  // duration register and its square
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dur_ticks <= DUR_RESET;
    end else if (cfg_valid) begin
      dur_ticks <= total_time;
    end
  end

  always_ff @(posedge clk) begin
    dur_sq <= DEN_SQ_W'(dur_ticks) * DEN_SQ_W'(dur_ticks);
  end

  // valid bits travel with the items
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  assign in_stall = !adv;

  // stage 1: classify time, pick base position, form end minus start
  logic              t_neg;
  logic              t_past;
  logic              st1_hold;
  logic [POS_W-1:0]  st1_base;
  logic [DIFF_W-1:0] st1_diff;
  logic [DUR_W-1:0]  st1_tq;

  assign t_neg  = time_now[TIME_W-1];
  assign t_past = !t_neg && (time_now[DUR_W-1:0] >= dur_ticks);

  always_ff @(posedge clk) begin
    if (adv) begin
      st1_hold <= t_neg || t_past;
      st1_base <= t_past ? end_pos : start_pos;
      st1_diff <= {end_pos[POS_W-1], end_pos} - {start_pos[POS_W-1], start_pos};
      st1_tq   <= time_now[DUR_W-1:0];
    end
  end

  // sideband beside the fraction divider
  side_t side_in;
  side_t side_d [FRAC_W];

  always_comb begin
    side_in.hold = st1_hold;
    side_in.dneg = st1_diff[DIFF_W-1];
    side_in.dm   = st1_diff[DIFF_W-1] ? DIFF_W'(0) - st1_diff : st1_diff;
    side_in.base = st1_base;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_d[0] <= side_in;
      for (int i = 1; i < FRAC_W; i++) begin
        side_d[i] <= side_d[i-1];
      end
    end
  end

  // time fraction s = time * 2^32 / duration
  logic [FRAC_W-1:0] frac_s;

  qtp_div #(
    .NUM_W (FRAC_W),
    .DEN_W (DUR_W)
  ) u_frac_div (
    .clk    (clk),
    .en     (adv),
    .den    (dur_ticks),
    .rem_in (st1_tq),
    .num_in (FRAC_W'(0)),
    .quo    (frac_s)
  );

  // stage m1: s^2, (1-s)^2, s(1-s), |1-2s|
  logic [ONE_W-1:0]    u_val;
  logic [2*FRAC_W-1:0] s_sq;
  logic [2*ONE_W-1:0]  u_sq;
  logic [FRAC_W+ONE_W-1:0] su;
  logic                w_neg;
  logic [ONE_W-1:0]    w_mag;
  logic [FRAC_W-1:0]   m1_s;
  logic [FRAC_W-1:0]   m1_s2;
  logic [ONE_W-1:0]    m1_u2;
  logic [FRAC_W-1:0]   m1_a;
  logic                m1_wneg;
  logic [ONE_W-1:0]    m1_wm;
  side_t               m1_side;

  assign u_val = ONE_Q - ONE_W'(frac_s);
  assign s_sq  = (2*FRAC_W)'(frac_s) * (2*FRAC_W)'(frac_s);
  assign u_sq  = (2*ONE_W)'(u_val) * (2*ONE_W)'(u_val);
  assign su    = (FRAC_W+ONE_W)'(frac_s) * (FRAC_W+ONE_W)'(u_val);
  assign w_neg = frac_s[FRAC_W-1] && (frac_s[FRAC_W-2:0] != '0);
  assign w_mag = w_neg ? {frac_s, 1'b0} - ONE_Q : ONE_Q - {frac_s, 1'b0};

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_s    <= frac_s;
      m1_s2   <= s_sq[2*FRAC_W-1:FRAC_W];
      m1_u2   <= u_sq[FRAC_W+ONE_W-1:FRAC_W];
      m1_a    <= su[2*FRAC_W-1:FRAC_W];
      m1_wneg <= w_neg;
      m1_wm   <= w_mag;
      m1_side <= side_d[FRAC_W-1];
    end
  end

  // stage m2: s^3, position polynomial, velocity and acceleration shapes
  logic [2*FRAC_W-1:0]     s3_prod;
  logic [POLY_W:0]         poly;
  logic [FRAC_W+ONE_W-1:0] v_prod;
  logic [FRAC_W+ONE_W-1:0] a_prod;
  logic [FRAC_W-1:0]       m2_s3;
  logic [POLY_W-1:0]       m2_p;
  logic [FRAC_W-1:0]       m2_v0;
  logic [FRAC_W-1:0]       m2_a0;
  logic                    m2_wneg;
  side_t                   m2_side;

  assign s3_prod = (2*FRAC_W)'(m1_s2) * (2*FRAC_W)'(m1_s);
  assign poly    = ((POLY_W+1)'(K_POS_10) << FRAC_W)
                 + (POLY_W+1)'(m1_s2) * (POLY_W+1)'(K_POS_6)
                 - (POLY_W+1)'(m1_s) * (POLY_W+1)'(K_POS_15);
  assign v_prod  = (FRAC_W+ONE_W)'(m1_s2) * (FRAC_W+ONE_W)'(m1_u2);
  assign a_prod  = (FRAC_W+ONE_W)'(m1_a) * (FRAC_W+ONE_W)'(m1_wm);

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_s3   <= s3_prod[2*FRAC_W-1:FRAC_W];
      m2_p    <= poly[POLY_W-1:0];
      // both shapes stay below one quarter, so the upper bit is always clear
      m2_v0   <= v_prod[2*FRAC_W-1:FRAC_W];
      m2_a0   <= a_prod[2*FRAC_W-1:FRAC_W];
      m2_wneg <= m1_wneg;
      m2_side <= m1_side;
    end
  end

  // stage m3: blend h = s^3 * poly, distance times the rate shapes
  logic [FRAC_W+POLY_W-1:0]  h_prod;
  logic [POLY_W-1:0]         h_raw;
  logic [DIFF_W+FRAC_W-1:0]  pv_prod;
  logic [DIFF_W+FRAC_W-1:0]  pa_prod;
  logic [FRAC_W-1:0]         m3_h;
  logic [DIFF_W+FRAC_W-1:0]  m3_pv;
  logic [DIFF_W+FRAC_W-1:0]  m3_pa;
  logic                      m3_wneg;
  side_t                     m3_side;

  assign h_prod  = (FRAC_W+POLY_W)'(m2_s3) * (FRAC_W+POLY_W)'(m2_p);
  assign h_raw   = h_prod[FRAC_W+POLY_W-1:FRAC_W];
  assign pv_prod = (DIFF_W+FRAC_W)'(m2_side.dm) * (DIFF_W+FRAC_W)'(m2_v0);
  assign pa_prod = (DIFF_W+FRAC_W)'(m2_side.dm) * (DIFF_W+FRAC_W)'(m2_a0);

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_h    <= (h_raw[POLY_W-1:FRAC_W] != '0) ? '1 : h_raw[FRAC_W-1:0];
      m3_pv   <= pv_prod;
      m3_pa   <= pa_prod;
      m3_wneg <= m2_wneg;
      m3_side <= m2_side;
    end
  end

  // stage m4: position offset and the dividends of velocity and acceleration
  localparam int XP_W = DIFF_W + FRAC_W + 5;
  localparam int YP_W = DIFF_W + FRAC_W + 6;

  logic [DIFF_W+FRAC_W-1:0] dp_prod;
  logic [XP_W-1:0]          x_prod;
  logic [YP_W-1:0]          y_prod;
  logic [DIFF_W-1:0]        m4_delta;
  logic [QUO_W-1:0]         m4_x;
  logic [QUO_W-1:0]         m4_y;
  logic                     m4_wneg;
  side_t                    m4_side;

  assign dp_prod = (DIFF_W+FRAC_W)'(m3_side.dm) * (DIFF_W+FRAC_W)'(m3_h);
  assign x_prod  = XP_W'(m3_pv) * XP_W'(K_VEL_30);
  assign y_prod  = YP_W'(m3_pa) * YP_W'(K_ACC_60);

  always_ff @(posedge clk) begin
    if (adv) begin
      m4_delta <= dp_prod[DIFF_W+FRAC_W-1:FRAC_W];
      m4_x     <= QUO_W'(x_prod[XP_W-1:16]);
      m4_y     <= QUO_W'(y_prod[YP_W-1:16]);
      m4_wneg  <= m3_wneg;
      m4_side  <= m3_side;
    end
  end

  // finished position and signs beside the rate dividers
  tail_t            tail_in;
  tail_t            tail_d [QUO_W];
  logic [POS_W-1:0] pos_move;

  assign pos_move = m4_side.dneg ? m4_side.base - m4_delta[POS_W-1:0]
                                 : m4_side.base + m4_delta[POS_W-1:0];

  always_comb begin
    tail_in.hold = m4_side.hold;
    tail_in.vneg = m4_side.dneg;
    tail_in.aneg = m4_side.dneg ^ m4_wneg;
    tail_in.pos  = m4_side.hold ? m4_side.base : pos_move;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tail_d[0] <= tail_in;
      for (int i = 1; i < QUO_W; i++) begin
        tail_d[i] <= tail_d[i-1];
      end
    end
  end

  // velocity: divide by duration; acceleration: divide by duration squared
  logic [QUO_W-1:0] vel_q;
  logic [QUO_W-1:0] acc_q;

  qtp_div #(
    .NUM_W (QUO_W),
    .DEN_W (DUR_W)
  ) u_vel_div (
    .clk    (clk),
    .en     (adv),
    .den    (dur_ticks),
    .rem_in (DUR_W'(0)),
    .num_in (m4_x),
    .quo    (vel_q)
  );

  qtp_div #(
    .NUM_W (QUO_W),
    .DEN_W (DEN_SQ_W)
  ) u_acc_div (
    .clk    (clk),
    .en     (adv),
    .den    (dur_sq),
    .rem_in (DEN_SQ_W'(0)),
    .num_in (m4_y),
    .quo    (acc_q)
  );

  // saturate and assemble the result item
  result_t res_next;
  tail_t   tail_out;

  assign tail_out = tail_d[QUO_W-1];

  always_comb begin
    res_next.pos = tail_out.pos;
    res_next.vel = tail_out.hold ? '0 : sat_rate(tail_out.vneg, vel_q);
    res_next.acc = tail_out.hold ? '0 : sat_rate(tail_out.aneg, acc_q);
  end

  // two-entry output buffer
  result_t    obuf [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] ocnt;
  logic [1:0] ocnt_next;
  logic       push;
  logic       pop;

  assign adv  = (ocnt != 2'd2);
  assign push = adv && vld[DEPTH-1];
  assign pop  = (ocnt != 2'd0) && !out_stall;

  always_comb begin
    case ({push, pop})
      2'b10:   ocnt_next = ocnt + 2'd1;
      2'b01:   ocnt_next = ocnt - 2'd1;
      default: ocnt_next = ocnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      ocnt   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      ocnt <= ocnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      obuf[wr_ptr] <= res_next;
    end
  end

  // output item
  assign out_valid        = (ocnt != 2'd0);
  assign ref_position     = obuf[rd_ptr].pos;
  assign ref_velocity     = obuf[rd_ptr].vel;
  assign ref_acceleration = obuf[rd_ptr].acc;

endmodule

`default_nettype wire
